@@ design/assert_macros.svh @@
// assertion helpers shared by the queue and back end design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cfd_pkg.sv @@
package cfd_pkg;

    localparam logic [63:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01B3;
    localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;

    // one classified input item
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } t_item;

    // one result item
    typedef struct packed {
        logic [31:0] crc_value;
        logic [63:0] fnv_hash;
        logic [63:0] byte_count;
    } t_digest;

    // reflected crc-32, one byte, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

    // fnv-1a step: prime is 2^40 + 0x1b3, so the product is shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] f, input logic [7:0] b);
        logic [63:0] x;
        x = f ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ design/cfd_front.sv @@
module cfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,
    input  logic           i_s_axis_tuser,
    input  logic           i_q_full,
    output logic           o_push,
    output cfd_pkg::t_item o_item
);
    import cfd_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_s_axis_tready = !r_valid || !i_q_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_q_full;
    assign o_item          = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // classify: kind selects end of stream, byte is kept only for data items
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.is_end <= i_s_axis_tuser;
            r_item.data   <= i_s_axis_tuser ? 8'd0 : i_s_axis_tdata;
        end
    end

endmodule

@@ design/cfd_queue.sv @@
`include "assert_macros.svh"

module cfd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cfd_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output cfd_pkg::t_item o_item,
    input  logic           i_pop
);
    import cfd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `CFD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(DEPTH), "queue count over depth")
    `CFD_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, do_push && !do_pop && !o_full,
        r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

@@ design/cfd_back.sv @@
`include "assert_macros.svh"

module cfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cfd_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output cfd_pkg::t_digest o_digest
);
    import cfd_pkg::*;

    logic [63:0] r_count;
    logic [63:0] r_fnv;
    logic [31:0] r_crc;
    logic        r_out_valid;
    t_digest     r_out;
    logic        take;
    logic        take_end;
    logic        out_free;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    // data items never wait on the result side
    assign o_pop           = i_valid && (!i_item.is_end || out_free);
    assign take            = o_pop;
    assign take_end        = take && i_item.is_end;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_digest        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fnv   <= FnvBasis;
            r_crc   <= CrcInit;
        end else if (take_end) begin
            r_count <= '0;
            r_fnv   <= FnvBasis;
            r_crc   <= CrcInit;
        end else if (take) begin
            if (r_count != '1) begin
                r_count <= r_count + 64'd1;
            end
            r_fnv <= fnv_step(r_fnv, i_item.data);
            r_crc <= crc_byte(r_crc, i_item.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_end) begin
            r_out.byte_count <= r_count;
            r_out.fnv_hash   <= (r_fnv == '0) ? FnvPrime : r_fnv;
            r_out.crc_value  <= r_crc ^ CrcInit;
        end
    end

    `CFD_ASSERT_NEXT(a_restart, i_clk, i_rst_n, take_end,
        r_count == '0 && r_fnv == FnvBasis && r_crc == CrcInit, "state not restarted")
    `CFD_ASSERT(a_result_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(take_end),
        "result without end item")

endmodule

@@ design/crc32_fnv1a64_stream_digest_unit.sv @@
// stream digest: byte count, fnv-1a 64 hash and reflected crc-32 over a byte stream
//
// input channel (s_axis): one item per handshake; tuser is the kind, 0 for a data
// byte carried in tdata[7:0], 1 for end of stream (tdata ignored)
// output channel (m_axis): one item per end of stream; tdata holds byte_count,
// fnv_hash and crc_value from the lowest bit up
// throughput: one input item per cycle while the queue is not full, set by the crc byte update
// and the fnv shift-add multiply, both done combinationally in the back end
// path: an end item goes from its input handshake through the front register and the queue
// into the result register, and from there onto m_axis
// reset: pipeline is flushed, running count 0, hash at the offset basis, crc all ones
// stall: a stalled m_axis holds its item; data bytes keep flowing behind it, and a
// following end item waits in the queue; once the queue fills, s_axis tready drops
// empty streams give count 0, the offset basis and crc 0; the count saturates
module crc32_fnv1a64_stream_digest_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // data_byte
    input  logic         i_s_axis_tuser,   // kind
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata    // byte_count, fnv_hash, crc_value
);
    import cfd_pkg::*;

    logic    q_full;
    logic    q_push;
    t_item   q_in;
    logic    q_valid;
    t_item   q_out;
    logic    q_pop;
    t_digest digest;

    cfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_item          (q_in)
    );

    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out),
        .i_pop   (q_pop)
    );

    cfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_item          (q_out),
        .o_pop           (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_digest        (digest)
    );

    assign o_m_axis_tdata = digest;

endmodule

@@ tb/tb_crc32_fnv1a64_stream_digest_unit.sv @@
`timescale 1ns / 1ps

module tb_crc32_fnv1a64_stream_digest_unit;

    import cfd_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 12;
    localparam int RandomItems   = 400;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'd0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;

    // running digest of the stream being sent
    logic [63:0]  run_count;
    logic [63:0]  run_fnv;
    logic [31:0]  run_crc;
    t_digest      pending_digests[$];

    int           mismatches   = 0;
    int           idle_cycles  = 0;
    int           stall_left   = 0;
    bit           no_idle      = 1'b0;

    crc32_fnv1a64_stream_digest_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // data_byte
        .i_s_axis_tuser  (s_tuser),   // kind
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // byte_count, fnv_hash, crc_value
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        lsb;
        r = c ^ {24'd0, b};
        repeat (8) begin
            lsb = r[0];
            r   = {1'b0, r[31:1]};
            if (lsb) begin
                r = r ^ CrcPoly;
            end
        end
        return r;
    endfunction

    task automatic restart_digest();
        run_count = 64'd0;
        run_fnv   = FnvBasis;
        run_crc   = CrcInit;
    endtask

    // fold one accepted item into the running digest; an end item closes the stream
    task automatic predict_item(input t_kind kind, input logic [7:0] b);
        t_digest d;
        if (kind == KIND_DATA) begin
            if (run_count != '1) begin
                run_count = run_count + 64'd1;
            end
            run_fnv = (run_fnv ^ {56'd0, b}) * FnvPrime;
            run_crc = crc32_update(run_crc, b);
        end else begin
            d.byte_count = run_count;
            d.fnv_hash   = (run_fnv == 64'd0) ? FnvPrime : run_fnv;
            d.crc_value  = run_crc ^ CrcInit;
            pending_digests.push_back(d);
            restart_digest();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        mismatches++;
        $display("mismatch %s: got %h expected %h at %0t", what, got_v, want_v, $time);
    endtask

    task automatic send_item(input t_kind kind, input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_item(kind, b);
    endtask

    task automatic send_stream(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        end
        // byte on an end item is ignored, so it is random too
        send_item(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    function automatic int stream_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return $urandom_range(40, 80);
        end
        if (r < 3) begin
            return 0;
        end
        return $urandom_range(1, 12);
    endfunction

    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_streams();
        send_item(KIND_END, 8'h00);
        send_item(KIND_END, 8'hFF);
        send_item(KIND_END, 8'h5A);
    endtask

    task automatic test_edge_bytes();
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_END, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_END, 8'hFF);
        send_item(KIND_DATA, 8'h55);
        send_item(KIND_DATA, 8'hAA);
        send_item(KIND_END, 8'h33);
    endtask

    // this byte sequence drives the fnv-1a 64 hash to zero
    task automatic test_zero_hash();
        logic [7:0] seq[8];
        seq = '{8'hD5, 8'h6B, 8'hB9, 8'h53, 8'h42, 8'h87, 8'h08, 8'h36};
        foreach (seq[k]) begin
            send_item(KIND_DATA, seq[k]);
        end
        send_item(KIND_END, 8'hA5);
    endtask

    task automatic test_random_streams(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = stream_len();
            send_stream(len);
            sent += len + 1;
        end
    endtask

    task automatic test_drain_pause();
        test_random_streams(40);
        wait_for_digests();
        test_random_streams(40);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_streams(80);
        for (int k = 0; k < 6; k++) begin
            send_item(KIND_END, 8'($urandom_range(0, 255)));
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_digest
        t_digest want;
        t_digest got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_digests.size() == 0) begin
                report_mismatch("digest with none pending", got.byte_count, 64'd0);
            end else begin
                want = pending_digests.pop_front();
                if (got.byte_count !== want.byte_count) begin
                    report_mismatch("byte_count", got.byte_count, want.byte_count);
                end
                if (got.fnv_hash !== want.fnv_hash) begin
                    report_mismatch("fnv_hash", got.fnv_hash, want.fnv_hash);
                end
                if (got.crc_value !== want.crc_value) begin
                    report_mismatch("crc_value", {32'd0, got.crc_value},
                                    {32'd0, want.crc_value});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        restart_digest();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_streams();
        test_edge_bytes();
        test_zero_hash();
        test_random_streams(RandomItems / 2);
        test_drain_pause();
        test_back_to_back();
        test_random_streams(RandomItems / 2);

        wait_for_digests();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
